### rtl/erm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_pkg: shared types and constants of the Euler rotation matrix unit
// Holds the CORDIC step constants, the datapath widths and the record that
// moves down the chain of CORDIC cells.
// ----------------------------------------------------------------------------
package erm_pkg;

  // Default configuration of the top level.
  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // Working format: binary angle of one turn in 32 bits, Q30 trig values.
  localparam int TURN_W    = 32;
  localparam int ITERS     = 30;
  localparam int WORK_FRAC = 30;
  localparam int CORDIC_W  = 34;
  localparam int Z_W       = 33;
  localparam int TRIG_W    = 32;
  localparam int PROD_W    = 2 * TRIG_W;
  localparam int MAT_W     = TRIG_W + 1;

  // Start value of x, which cancels the CORDIC gain.
  localparam logic [31:0] X_INIT = 32'h26DD3B6A;

  // Rounding constant for a Q30 by Q30 product.
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (WORK_FRAC - 1);

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TAB [ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // One angle in flight through the CORDIC chain.
  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic        [Z_W-1:0]      z;
    logic        [1:0]          quad;
  } lane_t;

  // One beat in flight: lane 0 is phi, lane 1 theta, lane 2 psi.
  typedef struct packed {
    lane_t [2:0] lane;
    logic        body;
  } cell_data_t;

  // Start a lane from a full-turn binary angle.
  function automatic lane_t lane_init(input logic [TURN_W-1:0] turn);
    lane_t l;
    l.x    = CORDIC_W'(X_INIT);
    l.y    = '0;
    l.z    = Z_W'(turn[TURN_W-3:0]);
    l.quad = turn[TURN_W-1:TURN_W-2];
    return l;
  endfunction

endpackage

### rtl/erm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_in_if: input channel of the Euler rotation matrix unit
// Carries one angle triple and the mode bit per beat.
// ----------------------------------------------------------------------------
interface erm_in_if import erm_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] angle_phi;
  logic [ANGLE_BITS-1:0] angle_theta;
  logic [ANGLE_BITS-1:0] angle_psi;
  logic                  body_mode;

  modport source (output valid, output angle_phi, output angle_theta,
                  output angle_psi, output body_mode, input ready);
  modport sink   (input valid, input angle_phi, input angle_theta,
                  input angle_psi, input body_mode, output ready);
endinterface

### rtl/erm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_out_if: result channel of the Euler rotation matrix unit
// Carries the nine matrix entries per beat.
// ----------------------------------------------------------------------------
interface erm_out_if import erm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [FRAC_BITS+1:0] row1_col1;
  logic signed [FRAC_BITS+1:0] row1_col2;
  logic signed [FRAC_BITS+1:0] row1_col3;
  logic signed [FRAC_BITS+1:0] row2_col1;
  logic signed [FRAC_BITS+1:0] row2_col2;
  logic signed [FRAC_BITS+1:0] row2_col3;
  logic signed [FRAC_BITS+1:0] row3_col1;
  logic signed [FRAC_BITS+1:0] row3_col2;
  logic signed [FRAC_BITS+1:0] row3_col3;

  modport source (output valid, output row1_col1, output row1_col2, output row1_col3,
                  output row2_col1, output row2_col2, output row2_col3,
                  output row3_col1, output row3_col2, output row3_col3, input ready);
  modport sink   (input valid, input row1_col1, input row1_col2, input row1_col3,
                  input row2_col1, input row2_col2, input row2_col3,
                  input row3_col1, input row3_col2, input row3_col3, output ready);
endinterface

### rtl/euler_rotation_matrix_unit.sv
`timescale 1ns / 1ps
// Path from an accepted input beat to its result beat: 30 CORDIC cells, then
// 5 product stages. Throughput: one beat per cycle unless the output stalls.
// Every stage has its own valid flag, so bubbles close up and the unit keeps
// accepting beats while a result waits at the output, until all stages fill.
// Reset clears only the valid flags; the unit carries no state between beats.
// ----------------------------------------------------------------------------
// euler_rotation_matrix_unit: z-x-z Euler angle rotation matrix
// Three binary angles run through a chain of CORDIC cells for sine and
// cosine, then a product pipeline forms the 3x3 matrix or its transpose.
// ----------------------------------------------------------------------------
module euler_rotation_matrix_unit import erm_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  erm_in_if.sink    in_bus,
  erm_out_if.source out_bus
);

  localparam int TURN_SHIFT = TURN_W - ANGLE_BITS;
  localparam logic signed [FRAC_BITS+1:0] ONE_OUT = (FRAC_BITS + 2)'(1) <<< FRAC_BITS;

  cell_data_t       chain_data [ITERS+1];
  logic [ITERS:0]   chain_valid;
  logic [ITERS:0]   chain_ready;

  // Scale each angle to a full 32-bit turn and start its lane.
  always_comb begin
    chain_data[0].lane[0] = lane_init(TURN_W'(in_bus.angle_phi) << TURN_SHIFT);
    chain_data[0].lane[1] = lane_init(TURN_W'(in_bus.angle_theta) << TURN_SHIFT);
    chain_data[0].lane[2] = lane_init(TURN_W'(in_bus.angle_psi) << TURN_SHIFT);
    chain_data[0].body    = in_bus.body_mode;
  end

  assign chain_valid[0] = in_bus.valid;
  assign in_bus.ready   = chain_ready[0];

  // Chain of CORDIC cells, one rotation step each.
  for (genvar g = 0; g < ITERS; g++) begin : g_cell
    erm_cordic_cell #(.STEP(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[g]),
      .up_ready (chain_ready[g]),
      .up_data  (chain_data[g]),
      .dn_valid (chain_valid[g+1]),
      .dn_ready (chain_ready[g+1]),
      .dn_data  (chain_data[g+1])
    );
  end

  // Quadrant fix-up, products and output register.
  erm_matrix_pipe #(.FRAC_BITS(FRAC_BITS)) u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (chain_valid[ITERS]),
    .up_ready (chain_ready[ITERS]),
    .up_data  (chain_data[ITERS]),
    .out_bus  (out_bus)
  );

  // A beat stalled at the end of the chain stays put until the pipe takes it.
  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    chain_valid[ITERS] && !chain_ready[ITERS]
      |=> chain_valid[ITERS] && $stable(chain_data[ITERS]))
    else $error("CORDIC chain dropped or changed a stalled beat");

  // Entries are clamped to plus or minus one; two corner entries are checked.
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> (out_bus.row1_col1 <= ONE_OUT) && (out_bus.row1_col1 >= -ONE_OUT)
      && (out_bus.row3_col3 <= ONE_OUT) && (out_bus.row3_col3 >= -ONE_OUT))
    else $error("matrix entry outside the clamp range");

  // Nothing is offered in the cycle after a reset cycle.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_bus.valid && !chain_valid[ITERS])
    else $error("pipeline not empty after reset");

endmodule

### rtl/erm_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_cordic_cell: one rotation step of the CORDIC chain
// Applies step STEP to all three angles of a beat and hands the result to
// the next cell. The cell holds its beat while the next cell is full.
// ----------------------------------------------------------------------------
module erm_cordic_cell import erm_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  cell_data_t up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output cell_data_t dn_data
);

  logic       valid_r;
  cell_data_t data_r;
  cell_data_t data_nxt;

  // The cell takes a beat when it is empty or its beat moves on.
  assign up_ready = ~valid_r | dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // Rotate each lane toward a zero residual angle.
  always_comb begin
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    data_nxt = up_data;
    for (int l = 0; l < 3; l++) begin
      dx = $signed(up_data.lane[l].y) >>> STEP;
      dy = $signed(up_data.lane[l].x) >>> STEP;
      if (!up_data.lane[l].z[Z_W-1]) begin
        data_nxt.lane[l].x = $signed(up_data.lane[l].x) - dx;
        data_nxt.lane[l].y = $signed(up_data.lane[l].y) + dy;
        data_nxt.lane[l].z = up_data.lane[l].z - Z_W'(ATAN_TAB[STEP]);
      end else begin
        data_nxt.lane[l].x = $signed(up_data.lane[l].x) + dx;
        data_nxt.lane[l].y = $signed(up_data.lane[l].y) - dy;
        data_nxt.lane[l].z = up_data.lane[l].z + Z_W'(ATAN_TAB[STEP]);
      end
    end
  end

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

### rtl/erm_matrix_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_matrix_pipe: sine/cosine fix-up and matrix product pipeline
// Maps the CORDIC outputs to the quadrant, forms the products over five
// stages and drives the result channel from its last stage.
// ----------------------------------------------------------------------------
module erm_matrix_pipe import erm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  cell_data_t up_data,
  erm_out_if.source  out_bus
);

  localparam int OUT_W = FRAC_BITS + 2;
  localparam int FIN_W = MAT_W + 1;
  localparam int SH    = WORK_FRAC - FRAC_BITS;
  localparam int SH_M1 = (SH > 0) ? SH - 1 : 0;
  localparam logic signed [FIN_W-1:0] HALF = (SH > 0) ? (FIN_W'(1) <<< SH_M1) : '0;
  localparam logic signed [FIN_W-1:0] ONE  = FIN_W'(1) <<< FRAC_BITS;

  // Round a Q60 product back to Q30.
  function automatic logic signed [TRIG_W-1:0] qround(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + ROUND_HALF;
    return s[WORK_FRAC+TRIG_W-1:WORK_FRAC];
  endfunction

  // Sign-extend a Q30 value to matrix width.
  function automatic logic signed [MAT_W-1:0] sx(input logic signed [TRIG_W-1:0] v);
    return MAT_W'(v);
  endfunction

  // Round to the output fraction and clamp to plus or minus one.
  function automatic logic signed [OUT_W-1:0] finish(input logic signed [MAT_W-1:0] v);
    logic signed [FIN_W-1:0] w;
    w = FIN_W'(v) + HALF;
    w = w >>> SH;
    if (w > ONE) begin
      w = ONE;
    end
    if (w < -ONE) begin
      w = -ONE;
    end
    return OUT_W'(w);
  endfunction

  // Stage handshake: a stage loads when empty or when its beat moves on.
  logic [4:0] valid_r;
  logic [4:0] adv;

  assign adv[4] = ~valid_r[4] | out_bus.ready;
  assign adv[3] = ~valid_r[3] | adv[4];
  assign adv[2] = ~valid_r[2] | adv[3];
  assign adv[1] = ~valid_r[1] | adv[2];
  assign adv[0] = ~valid_r[0] | adv[1];
  assign up_ready      = adv[0];
  assign out_bus.valid = valid_r[4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (adv[0]) begin
        valid_r[0] <= up_valid;
      end
      for (int k = 1; k < 5; k++) begin
        if (adv[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  // Stage A: quadrant fix-up and first-level products.
  logic signed [TRIG_W-1:0] cs_c [3];
  logic signed [TRIG_W-1:0] sn_c [3];
  logic signed [PROD_W-1:0] pa_nxt [10];
  logic signed [PROD_W-1:0] pa_r [10];
  logic signed [TRIG_W-1:0] cth_a_r;
  logic signed [TRIG_W-1:0] cps_a_r;
  logic signed [TRIG_W-1:0] sps_a_r;
  logic                     body_a_r;

  always_comb begin
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    for (int l = 0; l < 3; l++) begin
      x = $signed(up_data.lane[l].x);
      y = $signed(up_data.lane[l].y);
      case (up_data.lane[l].quad)
        2'd0: begin
          cs_c[l] = TRIG_W'(x);
          sn_c[l] = TRIG_W'(y);
        end
        2'd1: begin
          cs_c[l] = TRIG_W'(-y);
          sn_c[l] = TRIG_W'(x);
        end
        2'd2: begin
          cs_c[l] = TRIG_W'(-x);
          sn_c[l] = TRIG_W'(-y);
        end
        default: begin
          cs_c[l] = TRIG_W'(y);
          sn_c[l] = TRIG_W'(-x);
        end
      endcase
    end
    // Lane 0 is phi, lane 1 theta, lane 2 psi.
    pa_nxt[0] = cs_c[2] * cs_c[0];
    pa_nxt[1] = cs_c[1] * sn_c[0];
    pa_nxt[2] = cs_c[2] * sn_c[0];
    pa_nxt[3] = cs_c[1] * cs_c[0];
    pa_nxt[4] = sn_c[2] * sn_c[1];
    pa_nxt[5] = sn_c[2] * cs_c[0];
    pa_nxt[6] = cs_c[2] * sn_c[1];
    pa_nxt[7] = sn_c[2] * sn_c[0];
    pa_nxt[8] = sn_c[1] * sn_c[0];
    pa_nxt[9] = sn_c[1] * cs_c[0];
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pa_r     <= pa_nxt;
      cth_a_r  <= cs_c[1];
      cps_a_r  <= cs_c[2];
      sps_a_r  <= sn_c[2];
      body_a_r <= up_data.body;
    end
  end

  // Stage B: round the first-level products.
  logic signed [TRIG_W-1:0] rb_r [10];
  logic signed [TRIG_W-1:0] cth_b_r;
  logic signed [TRIG_W-1:0] cps_b_r;
  logic signed [TRIG_W-1:0] sps_b_r;
  logic                     body_b_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int k = 0; k < 10; k++) begin
        rb_r[k] <= qround(pa_r[k]);
      end
      cth_b_r  <= cth_a_r;
      cps_b_r  <= cps_a_r;
      sps_b_r  <= sps_a_r;
      body_b_r <= body_a_r;
    end
  end

  // Stage C: triple products with the psi terms.
  logic signed [PROD_W-1:0] tc_r [4];
  logic signed [TRIG_W-1:0] rc_r [10];
  logic signed [TRIG_W-1:0] cth_c_r;
  logic                     body_c_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      tc_r[0]  <= rb_r[1] * sps_b_r;
      tc_r[1]  <= rb_r[3] * sps_b_r;
      tc_r[2]  <= rb_r[1] * cps_b_r;
      tc_r[3]  <= rb_r[3] * cps_b_r;
      rc_r     <= rb_r;
      cth_c_r  <= cth_b_r;
      body_c_r <= body_b_r;
    end
  end

  // Stage D: combine into the nine Q30 entries, row-major.
  logic signed [MAT_W-1:0] md_nxt [9];
  logic signed [MAT_W-1:0] md_r [9];
  logic                    body_d_r;

  always_comb begin
    md_nxt[0] = sx(rc_r[0]) - sx(qround(tc_r[0]));
    md_nxt[1] = sx(rc_r[2]) + sx(qround(tc_r[1]));
    md_nxt[2] = sx(rc_r[4]);
    md_nxt[3] = -sx(rc_r[5]) - sx(qround(tc_r[2]));
    md_nxt[4] = -sx(rc_r[7]) + sx(qround(tc_r[3]));
    md_nxt[5] = sx(rc_r[6]);
    md_nxt[6] = sx(rc_r[8]);
    md_nxt[7] = -sx(rc_r[9]);
    md_nxt[8] = sx(cth_c_r);
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      md_r     <= md_nxt;
      body_d_r <= body_c_r;
    end
  end

  // Stage E: optional transpose, rounding and clamping into the output register.
  logic signed [OUT_W-1:0] out_r [9];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          out_r[r*3+c] <= finish(body_d_r ? md_r[c*3+r] : md_r[r*3+c]);
        end
      end
    end
  end

  assign out_bus.row1_col1 = out_r[0];
  assign out_bus.row1_col2 = out_r[1];
  assign out_bus.row1_col3 = out_r[2];
  assign out_bus.row2_col1 = out_r[3];
  assign out_bus.row2_col2 = out_r[4];
  assign out_bus.row2_col3 = out_r[5];
  assign out_bus.row3_col1 = out_r[6];
  assign out_bus.row3_col2 = out_r[7];
  assign out_bus.row3_col3 = out_r[8];

endmodule
